// ----- rtl/rrcw_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rrcw_pkg
// Shared widths, constants, tables and word types of the rotated rectangle
// crop window block.
// ----------------------------------------------------------------------------
package rrcw_pkg;

  localparam int FRAC_BITS         = 8;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int MAX_STAGES        = 24;
  localparam int DIM_BITS          = 16;

  localparam int CX_W   = 29;
  localparam int SIDE_W = 28;
  localparam int ANG_W  = 18;

  localparam int CFG_IDX_W        = 2;
  localparam int REG_IMAGE_WIDTH  = 0;
  localparam int REG_IMAGE_HEIGHT = 1;
  localparam int IMAGE_WIDTH_RST  = 640;
  localparam int IMAGE_HEIGHT_RST = 480;

  // angle reduction
  localparam int DEG180    = 180 << FRAC_BITS;
  localparam int DEG90     = 90 << FRAC_BITS;
  localparam int RED_OFFS  = ((2 ** (ANG_W - 1)) + DEG180 - 1) / DEG180 * DEG180;
  localparam int T_W       = $clog2((2 ** (ANG_W - 1)) + RED_OFFS);
  localparam int RED_STEPS = ((2 ** (ANG_W - 1)) - 1 + RED_OFFS) / DEG180;
  localparam int A_W       = $clog2(DEG90 + 1);

  // phase = round(a * 2^32 / (360 * 2^FRAC_BITS)), 360 * 2^F = 45 * 2^(F+3)
  localparam int PHASE_DIV  = 45;
  localparam int PHASE_BIAS = PHASE_DIV / 2;
  localparam int ZS         = 29 - FRAC_BITS;
  localparam int RECIP_SH   = 20;
  localparam int RECIP      = ((2 ** RECIP_SH) + PHASE_DIV - 1) / PHASE_DIV;
  localparam int RECIP_W    = $clog2(RECIP + 1);
  localparam int PROD_W     = A_W + RECIP_W;
  localparam int A1_W       = $clog2(DEG90 / PHASE_DIV + 2);
  localparam int A0_W       = $clog2(PHASE_DIV);
  localparam int REM_W      = A0_W + A1_W + 2;

  // CORDIC
  localparam int XY_W      = 33;
  localparam int Z_W       = 32;
  localparam int CORDIC_X0 = 652032874;

  localparam logic [31:0] ATAN_TURN [MAX_STAGES] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  typedef logic [ZS-1:0] frac_tab_t [PHASE_DIV];

  function automatic frac_tab_t build_frac_tab();
    frac_tab_t tab;
    for (int i = 0; i < PHASE_DIV; i++) begin
      tab[i] = ZS'((longint'(i) * (longint'(1) << ZS) + PHASE_BIAS) / PHASE_DIV);
    end
    return tab;
  endfunction

  localparam frac_tab_t FRAC_TAB = build_frac_tab();

  // back end
  localparam int C_W    = XY_W - 2;
  localparam int PR_W   = C_W + SIDE_W;
  localparam int HX_W   = PR_W + 1;
  localparam int CEN_SH = 31;
  localparam int EW     = 63;
  localparam int SH     = FRAC_BITS + CEN_SH;
  localparam int ESW    = EW - SH;

  typedef struct packed {
    logic signed [CX_W-1:0] cx;
    logic signed [CX_W-1:0] cy;
    logic [SIDE_W-1:0]      l1;
    logic [SIDE_W-1:0]      l2;
    logic signed [ANG_W-1:0] ang;
  } rect_t;

  typedef struct packed {
    logic signed [CX_W-1:0] cx;
    logic signed [CX_W-1:0] cy;
    logic [SIDE_W-1:0]      l1;
    logic [SIDE_W-1:0]      l2;
  } carry_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    carry_t                 p;
  } cordic_t;

endpackage
`default_nettype wire

// ----- rtl/rrcw_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rrcw_if
// Valid/ready channels of the crop window block: rectangle in, crop out.
// ----------------------------------------------------------------------------
interface rrcw_in_if;
  import rrcw_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [CX_W-1:0]  ctr_x;
  logic signed [CX_W-1:0]  ctr_y;
  logic [SIDE_W-1:0]       side_one;
  logic [SIDE_W-1:0]       side_two;
  logic signed [ANG_W-1:0] rot_ang;

  modport source (output valid, ctr_x, ctr_y, side_one, side_two, rot_ang,
                  input ready);
  modport sink (input valid, ctr_x, ctr_y, side_one, side_two, rot_ang,
                output ready);
endinterface

interface rrcw_out_if;
  import rrcw_pkg::*;
  logic                valid;
  logic                ready;
  logic                params_ok;
  logic                crop_valid;
  logic [DIM_BITS-1:0] crop_left;
  logic [DIM_BITS-1:0] crop_top;
  logic [DIM_BITS-1:0] crop_w;
  logic [DIM_BITS-1:0] crop_h;

  modport source (output valid, params_ok, crop_valid, crop_left, crop_top, crop_w,
                  crop_h, input ready);
  modport sink (input valid, params_ok, crop_valid, crop_left, crop_top, crop_w,
                crop_h, output ready);
endinterface
`default_nettype wire

// ----- rtl/rrcw_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rrcw_front
// Three stages: fold the angle into 0..90 degrees, estimate its quotient by 45,
// then form the binary-angle phase and the initial CORDIC word.
// ----------------------------------------------------------------------------
module rrcw_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  output logic              in_rdy,
  input  rrcw_pkg::rect_t   in_word,
  output logic              out_vld,
  input  logic              out_rdy,
  output rrcw_pkg::cordic_t out_word
);
  import rrcw_pkg::*;

  logic v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt;
  logic rdy1, rdy2, rdy3;

  logic signed [T_W:0] t_s;
  logic [T_W-1:0]      t_u;
  logic [T_W-1:0]      r_mod;
  logic [T_W-1:0]      a_fold;
  logic [A_W-1:0]      a1_r;
  carry_t              p1_r;

  logic [PROD_W-1:0]   prod;
  logic [A_W-1:0]      a2_r;
  logic [A1_W-1:0]     q2_r;
  carry_t              p2_r;

  logic signed [REM_W-1:0] rem;
  logic signed [REM_W-1:0] rem_c;
  logic [A1_W-1:0]         q_c;
  logic [A0_W-1:0]         a0;
  cordic_t                 word_nxt;
  cordic_t                 word3_r;

  assign rdy3   = !v3_r || out_rdy;
  assign rdy2   = !v2_r || rdy3;
  assign rdy1   = !v1_r || rdy2;
  assign in_rdy = rdy1;

  always_comb begin
    v1_nxt = rdy1 ? in_vld : v1_r;
    v2_nxt = rdy2 ? v1_r : v2_r;
    v3_nxt = rdy3 ? v2_r : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // stage 1: angle modulo 180 degrees, folded to 0..90
  always_comb begin
    t_s   = (T_W + 1)'(in_word.ang) + (T_W + 1)'(RED_OFFS);
    t_u   = t_s[T_W-1:0];
    r_mod = t_u;
    for (int k = 1; k <= RED_STEPS; k++) begin
      if (t_u >= T_W'(k * DEG180)) begin
        r_mod = t_u - T_W'(k * DEG180);
      end
    end
    if (r_mod > T_W'(DEG90)) begin
      a_fold = T_W'(DEG180) - r_mod;
    end else begin
      a_fold = r_mod;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld && rdy1) begin
      a1_r  <= A_W'(a_fold);
      p1_r.cx <= in_word.cx;
      p1_r.cy <= in_word.cy;
      p1_r.l1 <= in_word.l1;
      p1_r.l2 <= in_word.l2;
    end
  end

  // stage 2: quotient by 45 through the reciprocal
  assign prod = PROD_W'(a1_r) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (v1_r && rdy2) begin
      a2_r <= a1_r;
      q2_r <= A1_W'(prod >> RECIP_SH);
      p2_r <= p1_r;
    end
  end

  // stage 3: correct the quotient, look up the fraction, build the phase
  always_comb begin
    rem = $signed(REM_W'(a2_r)) - $signed(REM_W'(q2_r * PHASE_DIV));
    if (rem < 0) begin
      q_c   = q2_r - A1_W'(1);
      rem_c = rem + REM_W'(PHASE_DIV);
    end else if (rem >= REM_W'(PHASE_DIV)) begin
      q_c   = q2_r + A1_W'(1);
      rem_c = rem - REM_W'(PHASE_DIV);
    end else begin
      q_c   = q2_r;
      rem_c = rem;
    end
    a0         = A0_W'(rem_c);
    word_nxt.x = XY_W'(CORDIC_X0);
    word_nxt.y = '0;
    word_nxt.z = Z_W'({q_c, FRAC_TAB[a0]});
    word_nxt.p = p2_r;
  end

  always_ff @(posedge clk) begin
    if (v2_r && rdy3) begin
      word3_r <= word_nxt;
    end
  end

  assign out_vld  = v3_r;
  assign out_word = word3_r;

endmodule
`default_nettype wire

// ----- rtl/rrcw_cordic_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rrcw_cordic_cell
// One rotation-mode CORDIC iteration with its own valid bit and word register.
// ----------------------------------------------------------------------------
module rrcw_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  output logic              in_rdy,
  input  rrcw_pkg::cordic_t in_word,
  output logic              out_vld,
  input  logic              out_rdy,
  output rrcw_pkg::cordic_t out_word
);
  import rrcw_pkg::*;

  logic                   vld_r, vld_nxt;
  cordic_t                word_r, word_nxt;
  logic signed [XY_W-1:0] x_in, y_in, dx, dy;
  logic signed [Z_W-1:0]  z_in, step;

  assign in_rdy = !vld_r || out_rdy;

  always_comb begin
    x_in     = in_word.x;
    y_in     = in_word.y;
    z_in     = in_word.z;
    dx       = y_in >>> STAGE;
    dy       = x_in >>> STAGE;
    step     = $signed(ATAN_TURN[STAGE]);
    word_nxt = in_word;
    if (!z_in[Z_W-1]) begin
      word_nxt.x = x_in - dx;
      word_nxt.y = y_in + dy;
      word_nxt.z = z_in - step;
    end else begin
      word_nxt.x = x_in + dx;
      word_nxt.y = y_in - dy;
      word_nxt.z = z_in + step;
    end
    vld_nxt = in_rdy ? in_vld : vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld && in_rdy) begin
      word_r <= word_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_word = word_r;

endmodule
`default_nettype wire

// ----- rtl/rrcw_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rrcw_back
// Five stages: magnitudes, products, half extents, floored and ceiled edges,
// then clamping into the output register.
// ----------------------------------------------------------------------------
module rrcw_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  output logic                          in_rdy,
  input  rrcw_pkg::cordic_t             in_word,
  input  logic [rrcw_pkg::DIM_BITS-1:0] img_w,
  input  logic [rrcw_pkg::DIM_BITS-1:0] img_h,
  output logic                          out_vld,
  input  logic                          out_rdy,
  output logic                          params_ok,
  output logic                          crop_valid,
  output logic [rrcw_pkg::DIM_BITS-1:0] crop_left,
  output logic [rrcw_pkg::DIM_BITS-1:0] crop_top,
  output logic [rrcw_pkg::DIM_BITS-1:0] crop_w,
  output logic [rrcw_pkg::DIM_BITS-1:0] crop_h
);
  import rrcw_pkg::*;

  logic [5:1] v_r, v_nxt;
  logic [5:1] rdy;

  logic signed [XY_W-1:0] x_in, y_in;
  logic [XY_W-1:0]        x_abs, y_abs;

  logic [C_W-1:0]         c1_r, s1_r;
  logic [SIDE_W-1:0]      l11_r, l21_r;
  logic signed [CX_W-1:0] cx1_r, cy1_r, cx2_r, cy2_r, cx3_r, cy3_r;
  logic                   ok1_r, ok2_r, ok3_r, ok4_r;

  logic [PR_W-1:0] pc1_r, ps2_r, ps1_r, pc2_r;
  logic [HX_W-1:0] hx3_r, hy3_r;

  logic signed [EW-1:0]  cxs, cys, hxe, hye, ceil_add;
  logic signed [EW-1:0]  x_lo, x_hi, y_lo, y_hi;
  logic signed [ESW-1:0] x0_r, x1_r, y0_r, y1_r;

  logic signed [ESW-1:0] x0c, y0c, x1c, y1c, wd, ht;
  logic signed [ESW:0]   w_d, h_d;
  logic                  valid_d;

  logic                ok5_r, valid5_r;
  logic [DIM_BITS-1:0] left5_r, top5_r, width5_r, height5_r;

  assign rdy[5] = !v_r[5] || out_rdy;
  assign rdy[4] = !v_r[4] || rdy[5];
  assign rdy[3] = !v_r[3] || rdy[4];
  assign rdy[2] = !v_r[2] || rdy[3];
  assign rdy[1] = !v_r[1] || rdy[2];
  assign in_rdy = rdy[1];

  always_comb begin
    v_nxt[1] = rdy[1] ? in_vld : v_r[1];
    for (int k = 2; k <= 5; k++) begin
      v_nxt[k] = rdy[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // stage 1: |cos| and |sin|
  always_comb begin
    x_in  = in_word.x;
    y_in  = in_word.y;
    x_abs = x_in[XY_W-1] ? XY_W'(-x_in) : XY_W'(x_in);
    y_abs = y_in[XY_W-1] ? XY_W'(-y_in) : XY_W'(y_in);
  end

  always_ff @(posedge clk) begin
    if (in_vld && rdy[1]) begin
      c1_r  <= C_W'(x_abs);
      s1_r  <= C_W'(y_abs);
      l11_r <= in_word.p.l1;
      l21_r <= in_word.p.l2;
      cx1_r <= in_word.p.cx;
      cy1_r <= in_word.p.cy;
      ok1_r <= (in_word.p.l1 != '0) && (in_word.p.l2 != '0);
    end
  end

  // stage 2: products
  always_ff @(posedge clk) begin
    if (v_r[1] && rdy[2]) begin
      pc1_r <= PR_W'(c1_r) * PR_W'(l11_r);
      ps2_r <= PR_W'(s1_r) * PR_W'(l21_r);
      ps1_r <= PR_W'(s1_r) * PR_W'(l11_r);
      pc2_r <= PR_W'(c1_r) * PR_W'(l21_r);
      cx2_r <= cx1_r;
      cy2_r <= cy1_r;
      ok2_r <= ok1_r;
    end
  end

  // stage 3: half extents
  always_ff @(posedge clk) begin
    if (v_r[2] && rdy[3]) begin
      hx3_r <= HX_W'(pc1_r) + HX_W'(ps2_r);
      hy3_r <= HX_W'(ps1_r) + HX_W'(pc2_r);
      cx3_r <= cx2_r;
      cy3_r <= cy2_r;
      ok3_r <= ok2_r;
    end
  end

  // stage 4: floor of the low edges, ceiling of the high edges
  always_comb begin
    cxs      = EW'(cx3_r) <<< CEN_SH;
    cys      = EW'(cy3_r) <<< CEN_SH;
    hxe      = $signed(EW'(hx3_r));
    hye      = $signed(EW'(hy3_r));
    ceil_add = $signed({{(EW - SH){1'b0}}, {SH{1'b1}}});
    x_lo     = cxs - hxe;
    y_lo     = cys - hye;
    x_hi     = cxs + hxe + ceil_add;
    y_hi     = cys + hye + ceil_add;
  end

  always_ff @(posedge clk) begin
    if (v_r[3] && rdy[4]) begin
      x0_r  <= ESW'(x_lo >>> SH);
      y0_r  <= ESW'(y_lo >>> SH);
      x1_r  <= ESW'(x_hi >>> SH);
      y1_r  <= ESW'(y_hi >>> SH);
      ok4_r <= ok3_r;
    end
  end

  // stage 5: clamp to the image
  always_comb begin
    wd      = $signed({{(ESW - DIM_BITS){1'b0}}, img_w});
    ht      = $signed({{(ESW - DIM_BITS){1'b0}}, img_h});
    x0c     = x0_r[ESW-1] ? '0 : x0_r;
    y0c     = y0_r[ESW-1] ? '0 : y0_r;
    x1c     = (x1_r > wd) ? wd : x1_r;
    y1c     = (y1_r > ht) ? ht : y1_r;
    w_d     = (ESW + 1)'(x1c) - (ESW + 1)'(x0c);
    h_d     = (ESW + 1)'(y1c) - (ESW + 1)'(y0c);
    valid_d = (w_d > 0) && (h_d > 0);
  end

  always_ff @(posedge clk) begin
    if (v_r[4] && rdy[5]) begin
      ok5_r     <= ok4_r;
      valid5_r  <= valid_d;
      left5_r   <= valid_d ? DIM_BITS'(x0c) : '0;
      top5_r    <= valid_d ? DIM_BITS'(y0c) : '0;
      width5_r  <= valid_d ? DIM_BITS'(w_d) : '0;
      height5_r <= valid_d ? DIM_BITS'(h_d) : '0;
    end
  end

  assign out_vld    = v_r[5];
  assign params_ok  = ok5_r;
  assign crop_valid = valid5_r;
  assign crop_left  = left5_r;
  assign crop_top   = top5_r;
  assign crop_w     = width5_r;
  assign crop_h     = height5_r;

endmodule
`default_nettype wire

// ----- rtl/rotated_rect_crop_window_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rotated_rect_crop_window_top
// Axis-aligned crop window of a rotated rectangle, clamped to the image.
//
//   channel  dir  handshake     word
//   in_ch    in   valid/ready   ctr_x, ctr_y, side_one, side_two, rot_ang
//   out_ch   out  valid/ready   params_ok, crop_valid, crop_left, crop_top, crop_w, crop_h
//   cfg_*    in   write enable  image_width (index 0), image_height (index 1)
//
// One word per cycle while the output is not stalled; 3 phase stages, one
// cell per CORDIC iteration, 5 bounding box stages.
// Reset empties every stage and sets the image size to 640 x 480.
// Each stage holds its word while the next is full; a stalled output backs
// up stage by stage, and empty stages keep filling.
// ----------------------------------------------------------------------------
module rotated_rect_crop_window_top #(
  parameter int CORDIC_STAGES = rrcw_pkg::CORDIC_STAGES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rrcw_in_if.sink                        in_ch,
  rrcw_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [rrcw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rrcw_pkg::DIM_BITS-1:0]  cfg_wdata
);
  import rrcw_pkg::*;

  logic [DIM_BITS-1:0] img_w_r, img_h_r;

  rect_t                in_word;
  logic [CORDIC_STAGES:0] c_vld;
  logic [CORDIC_STAGES:0] c_rdy;
  cordic_t              c_word [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= DIM_BITS'(IMAGE_WIDTH_RST);
      img_h_r <= DIM_BITS'(IMAGE_HEIGHT_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_W'(REG_IMAGE_WIDTH):  img_w_r <= cfg_wdata;
        CFG_IDX_W'(REG_IMAGE_HEIGHT): img_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_word.cx  = in_ch.ctr_x;
    in_word.cy  = in_ch.ctr_y;
    in_word.l1  = in_ch.side_one;
    in_word.l2  = in_ch.side_two;
    in_word.ang = in_ch.rot_ang;
  end

  rrcw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_ch.valid),
    .in_rdy   (in_ch.ready),
    .in_word  (in_word),
    .out_vld  (c_vld[0]),
    .out_rdy  (c_rdy[0]),
    .out_word (c_word[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    rrcw_cordic_cell #(
      .STAGE (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (c_vld[g]),
      .in_rdy   (c_rdy[g]),
      .in_word  (c_word[g]),
      .out_vld  (c_vld[g+1]),
      .out_rdy  (c_rdy[g+1]),
      .out_word (c_word[g+1])
    );
  end

  rrcw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (c_vld[CORDIC_STAGES]),
    .in_rdy     (c_rdy[CORDIC_STAGES]),
    .in_word    (c_word[CORDIC_STAGES]),
    .img_w      (img_w_r),
    .img_h      (img_h_r),
    .out_vld    (out_ch.valid),
    .out_rdy    (out_ch.ready),
    .params_ok  (out_ch.params_ok),
    .crop_valid (out_ch.crop_valid),
    .crop_left  (out_ch.crop_left),
    .crop_top   (out_ch.crop_top),
    .crop_w     (out_ch.crop_w),
    .crop_h     (out_ch.crop_h)
  );

endmodule
`default_nettype wire
